// File: sv/sfb_pkg.sv
// Shared constants and types for the serial port FIFO buffer.
package sfb_pkg;

   localparam int RX_DEPTH = 64;
   localparam int TX_DEPTH = 64;
   localparam int RX_AW    = $clog2(RX_DEPTH);
   localparam int TX_AW    = $clog2(TX_DEPTH);

   localparam logic [1:0] KIND_APP_READ  = 2'd0;
   localparam logic [1:0] KIND_APP_WRITE = 2'd1;
   localparam logic [1:0] KIND_RX_BYTE   = 2'd2;
   localparam logic [1:0] KIND_TX_DONE   = 2'd3;

   localparam int RSP_BITS  = 20;
   localparam int RSP_BYTES = (RSP_BITS + 7) / 8;

   typedef struct packed {
      logic             wr_en;
      logic [RX_AW-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [RX_AW-1:0] rd_addr;
   } rx_cmd_type;

   typedef struct packed {
      logic             wr_en;
      logic [TX_AW-1:0] wr_addr;
      logic [7:0]       wr_data;
      logic             rd_en;
      logic [TX_AW-1:0] rd_addr;
   } tx_cmd_type;

   // per-word result info carried alongside the memory read
   typedef struct packed {
      logic       read_valid;
      logic       tx_start;
      logic       tx_bypass;
      logic       tx_stop;
      logic       dropped;
      logic [7:0] data_byte;
   } info_type;

endpackage

// File: sv/serial_port_fifo_buffer.sv
// Top level: serial port receive and transmit ring buffers.
//
//  channel | dir | tdata                         | tuser
//  req_    | in  | [7:0] data_byte               | [1:0] kind
//  rsp_    | out | read_valid..dropped (see port) | -
//
//  One word per cycle while rsp_ is not stalled; each result passes stage s1
//  (aligned with the registered read port of each ring memory), then the output register.
//  Reset clears pointers, busy flag and both pipeline stages; memories keep contents.
//  A stalled rsp_ holds the pipeline; req_tready drops once both stages are full and rsp_ is stalled.
module serial_port_fifo_buffer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] data_byte
   input  logic [1:0]                         req_tuser,  // [1:0] kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] read_valid, [8:1] read_data, [9] tx_start, [17:10] tx_data,
   // [18] tx_stop, [19] dropped, rest zero
   output logic [8*sfb_pkg::RSP_BYTES-1:0]    rsp_tdata
);

   sfb_pkg::rx_cmd_type rx_cmd;
   sfb_pkg::tx_cmd_type tx_cmd;
   sfb_pkg::info_type   info;
   sfb_pkg::info_type   s1_info_ff, s1_info_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic [8*sfb_pkg::RSP_BYTES-1:0] out_data_ff, out_data_in;
   logic                accept, s1_adv;
   logic [7:0]          rx_rd_data, tx_rd_data;
   logic [7:0]          read_data, tx_data;

   assign s1_adv     = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   sfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .kind      (req_tuser),
      .data_byte (req_tdata),
      .rx_cmd    (rx_cmd),
      .tx_cmd    (tx_cmd),
      .info      (info)
   );

   sfb_ram #(.WIDTH(8), .DEPTH(sfb_pkg::RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_cmd.wr_en),
      .wr_addr (rx_cmd.wr_addr),
      .wr_data (rx_cmd.wr_data),
      .rd_en   (rx_cmd.rd_en),
      .rd_addr (rx_cmd.rd_addr),
      .rd_data (rx_rd_data)
   );

   sfb_ram #(.WIDTH(8), .DEPTH(sfb_pkg::TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_cmd.wr_en),
      .wr_addr (tx_cmd.wr_addr),
      .wr_data (tx_cmd.wr_data),
      .rd_en   (tx_cmd.rd_en),
      .rd_addr (tx_cmd.rd_addr),
      .rd_data (tx_rd_data)
   );

   assign read_data = s1_info_ff.read_valid ? rx_rd_data : 8'h00;
   assign tx_data   = !s1_info_ff.tx_start ? 8'h00
                      : (s1_info_ff.tx_bypass ? s1_info_ff.data_byte : tx_rd_data);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_info_in   = s1_info_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (s1_adv) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_data_in = {(8*sfb_pkg::RSP_BYTES)'(0)};
            out_data_in[sfb_pkg::RSP_BITS-1:0] = {s1_info_ff.dropped, s1_info_ff.tx_stop,
                                                  tx_data, s1_info_ff.tx_start,
                                                  read_data, s1_info_ff.read_valid};
         end
      end
      if (req_tready) begin
         s1_valid_in = accept;
         s1_info_in  = info;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_info_ff  <= s1_info_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: sv/sfb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sfb_ctrl.sv
// Ring pointers, transmitter-busy flag and per-word memory command decode.
module sfb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [1:0]          kind,
   input  logic [7:0]          data_byte,
   output sfb_pkg::rx_cmd_type rx_cmd,
   output sfb_pkg::tx_cmd_type tx_cmd,
   output sfb_pkg::info_type   info
);

   logic [sfb_pkg::RX_AW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in;
   logic [sfb_pkg::TX_AW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in;
   logic                      busy_ff, busy_in;
   logic [sfb_pkg::RX_AW-1:0] rx_wp_nx, rx_rp_nx;
   logic [sfb_pkg::TX_AW-1:0] tx_wp_nx, tx_rp_nx;

   assign rx_wp_nx = (rx_wp_ff == sfb_pkg::RX_AW'(sfb_pkg::RX_DEPTH - 1)) ? '0
                     : rx_wp_ff + 1'b1;
   assign rx_rp_nx = (rx_rp_ff == sfb_pkg::RX_AW'(sfb_pkg::RX_DEPTH - 1)) ? '0
                     : rx_rp_ff + 1'b1;
   assign tx_wp_nx = (tx_wp_ff == sfb_pkg::TX_AW'(sfb_pkg::TX_DEPTH - 1)) ? '0
                     : tx_wp_ff + 1'b1;
   assign tx_rp_nx = (tx_rp_ff == sfb_pkg::TX_AW'(sfb_pkg::TX_DEPTH - 1)) ? '0
                     : tx_rp_ff + 1'b1;

   always_comb begin
      rx_wp_in = rx_wp_ff;
      rx_rp_in = rx_rp_ff;
      tx_wp_in = tx_wp_ff;
      tx_rp_in = tx_rp_ff;
      busy_in  = busy_ff;

      rx_cmd.wr_en   = 1'b0;
      rx_cmd.wr_addr = rx_wp_ff;
      rx_cmd.wr_data = data_byte;
      rx_cmd.rd_en   = 1'b0;
      rx_cmd.rd_addr = rx_rp_ff;
      tx_cmd.wr_en   = 1'b0;
      tx_cmd.wr_addr = tx_wp_ff;
      tx_cmd.wr_data = data_byte;
      tx_cmd.rd_en   = 1'b0;
      tx_cmd.rd_addr = tx_rp_ff;

      info            = '0;
      info.data_byte  = data_byte;

      if (accept) begin
         case (kind)
            sfb_pkg::KIND_APP_READ: begin
               if (rx_wp_ff != rx_rp_ff) begin
                  info.read_valid = 1'b1;
                  rx_cmd.rd_en    = 1'b1;
                  rx_rp_in        = rx_rp_nx;
               end
            end
            sfb_pkg::KIND_APP_WRITE: begin
               if (tx_wp_nx == tx_rp_ff) begin
                  info.dropped = 1'b1;
               end else begin
                  tx_cmd.wr_en = 1'b1;
                  tx_wp_in     = tx_wp_nx;
                  if (!busy_ff) begin
                     tx_rp_in       = tx_rp_nx;
                     busy_in        = 1'b1;
                     info.tx_start  = 1'b1;
                     info.tx_bypass = 1'b1;
                  end
               end
            end
            sfb_pkg::KIND_RX_BYTE: begin
               if (rx_wp_nx == rx_rp_ff) begin
                  info.dropped = 1'b1;
               end else begin
                  rx_cmd.wr_en = 1'b1;
                  rx_wp_in     = rx_wp_nx;
               end
            end
            sfb_pkg::KIND_TX_DONE: begin
               if (tx_wp_ff == tx_rp_ff) begin
                  busy_in      = 1'b0;
                  info.tx_stop = 1'b1;
               end else begin
                  tx_cmd.rd_en  = 1'b1;
                  tx_rp_in      = tx_rp_nx;
                  busy_in       = 1'b1;
                  info.tx_start = 1'b1;
               end
            end
            default: begin
               info = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff <= '0;
         rx_rp_ff <= '0;
         tx_wp_ff <= '0;
         tx_rp_ff <= '0;
         busy_ff  <= 1'b0;
      end else begin
         rx_wp_ff <= rx_wp_in;
         rx_rp_ff <= rx_rp_in;
         tx_wp_ff <= tx_wp_in;
         tx_rp_ff <= tx_rp_in;
         busy_ff  <= busy_in;
      end
   end

endmodule

// File: sv/sfb_checker.sv
// Port-level checks for the serial port FIFO buffer, bound to the top level.
module sfb_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [7:0]                      req_tdata,
   input logic [1:0]                      req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [8*sfb_pkg::RSP_BYTES-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[9] && rsp_tdata[18]))
      else $error("tx_start and tx_stop together");

   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[8:1] == 8'h00)
                  && (rsp_tdata[9] || rsp_tdata[17:10] == 8'h00))
      else $error("data field set without its valid flag");

   a_drop_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> !rsp_tdata[0] && !rsp_tdata[9] && !rsp_tdata[18])
      else $error("dropped word carries other events");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind serial_port_fifo_buffer sfb_checker u_sfb_checker (.*);
